[hw/rtl/jrs_pkg.sv]
// Shared types and constants for the jittered report scheduler.
package jrs_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned GAP_W  = 20;
  localparam int unsigned JIT_W  = 16;
  localparam int unsigned ADDR_W = 3;

  localparam logic signed [7:0] RSSI_NONE = -8'sd127;
  localparam logic [GAP_W-1:0] MIN_GAP_RST = 20'd1000;
  localparam logic [GAP_W-1:0] HB_GAP_RST  = 20'd5000;

  typedef enum logic [0:0] {
    REG_MIN_GAP = 1'b0,
    REG_HB_GAP  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [GAP_W-1:0] min_report_gap_ms;
    logic [GAP_W-1:0] heartbeat_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              pkt_heard;
    logic [31:0]       pkt_count;
    logic signed [7:0] pkt_rssi;
    logic [JIT_W-1:0]  report_jitter_ms;
    logic [JIT_W-1:0]  heartbeat_jitter_ms;
    logic              fix_valid;
    logic [31:0]       latitude_bits;
    logic [31:0]       longitude_bits;
    logic [31:0]       altitude_bits;
    logic [7:0]        sats_in_view;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] report_time;
    logic [31:0]       report_seq;
    logic [31:0]       sat_seq;
    logic [TIME_W-1:0] sat_time;
    logic signed [7:0] sat_rssi;
    logic              fix_flag;
    logic [31:0]       latitude;
    logic [31:0]       longitude;
    logic [31:0]       altitude;
    logic [7:0]        sats;
  } result_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] seq;
  } core_stat_t;

endpackage

[hw/rtl/jittered_report_scheduler.sv]
// Jittered report scheduler top level: input register, core, result register.
// Flow: an accepted item is held in the input register and evaluated when the result
//   register can take it; its report, if any, is presented from the result register.
// Throughput: one item per cycle unless stalled; set by single input reg and core step.
// Reset (rst_n low, synchronous): scheduler state and registers take their reset values,
//   both pipeline registers empty.
module jittered_report_scheduler import jrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_now_ms,
  input  logic              in_pkt_heard,
  input  logic [31:0]       in_pkt_count,
  input  logic signed [7:0] in_pkt_rssi,
  input  logic [15:0]       in_report_jitter_ms,
  input  logic [15:0]       in_heartbeat_jitter_ms,
  input  logic              in_fix_valid,
  input  logic [31:0]       in_latitude_bits,
  input  logic [31:0]       in_longitude_bits,
  input  logic [31:0]       in_altitude_bits,
  input  logic [7:0]        in_sats_in_view,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_report_time,
  output logic [31:0]       out_report_seq,
  output logic [31:0]       out_sat_seq,
  output logic [31:0]       out_sat_time,
  output logic signed [7:0] out_sat_rssi,
  output logic              out_fix_flag,
  output logic [31:0]       out_latitude,
  output logic [31:0]       out_longitude,
  output logic [31:0]       out_altitude,
  output logic [7:0]        out_sats,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  in_item_t   stage_r;
  logic       stage_valid_r;
  result_t    res, out_r;
  logic       out_valid_r;
  core_stat_t stat;
  logic       step_en;

  assign step_en  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || step_en;

  jrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jrs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (stage_r),
    .cfg     (cfg),
    .res     (res),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.now_ms              <= in_now_ms;
      stage_r.pkt_heard           <= in_pkt_heard;
      stage_r.pkt_count           <= in_pkt_count;
      stage_r.pkt_rssi            <= in_pkt_rssi;
      stage_r.report_jitter_ms    <= in_report_jitter_ms;
      stage_r.heartbeat_jitter_ms <= in_heartbeat_jitter_ms;
      stage_r.fix_valid           <= in_fix_valid;
      stage_r.latitude_bits       <= in_latitude_bits;
      stage_r.longitude_bits      <= in_longitude_bits;
      stage_r.altitude_bits       <= in_altitude_bits;
      stage_r.sats_in_view        <= in_sats_in_view;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fire) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_time = out_r.report_time;
  assign out_report_seq  = out_r.report_seq;
  assign out_sat_seq     = out_r.sat_seq;
  assign out_sat_time    = out_r.sat_time;
  assign out_sat_rssi    = out_r.sat_rssi;
  assign out_fix_flag    = out_r.fix_flag;
  assign out_latitude    = out_r.latitude;
  assign out_longitude   = out_r.longitude;
  assign out_altitude    = out_r.altitude;
  assign out_sats        = out_r.sats;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !stat.fire)
    else $error("report fired while result register stalled");

  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire |=> (out_valid && out_report_time == $past(stage_r.now_ms)))
    else $error("fired report not presented with its time");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire |=> (stat.seq == $past(stat.seq) + 32'd1))
    else $error("sequence did not advance on report");

  a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.fire |=> $stable(stat.seq))
    else $error("sequence changed without report");

endmodule

[hw/rtl/jrs_cfg.sv]
// APB-style configuration registers for the report scheduler.
module jrs_cfg import jrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_report_gap_ms <= MIN_GAP_RST;
      cfg_r.heartbeat_gap_ms  <= HB_GAP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_GAP: cfg_r.min_report_gap_ms <= pwdata[GAP_W-1:0];
        REG_HB_GAP:  cfg_r.heartbeat_gap_ms  <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_GAP: prdata = {{(32-GAP_W){1'b0}}, cfg_r.min_report_gap_ms};
      REG_HB_GAP:  prdata = {{(32-GAP_W){1'b0}}, cfg_r.heartbeat_gap_ms};
      default:     prdata = '0;
    endcase
  end

endmodule

[hw/rtl/jrs_core.sv]
// Scheduler state and per-item decision logic.
module jrs_core import jrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_item_t   item,
  input  cfg_t       cfg,
  output result_t    res,
  output core_stat_t stat
);

  logic              ever_r,       ever_nxt;
  logic [31:0]       held_cnt_r,   held_cnt_nxt;
  logic [TIME_W-1:0] held_time_r,  held_time_nxt;
  logic signed [7:0] held_rssi_r,  held_rssi_nxt;
  logic [31:0]       seq_r,        seq_nxt;
  logic [TIME_W-1:0] last_send_r,  last_send_nxt;
  logic              pending_r,    pending_nxt;
  logic [TIME_W-1:0] due_r,        due_nxt;

  logic [TIME_W-1:0] min_gap, hb_gap;
  logic [TIME_W-1:0] rep_due, floor_t, since_pkt, since_send;
  logic              silent, recent, fire;

  assign min_gap = {{(TIME_W-GAP_W){1'b0}}, cfg.min_report_gap_ms};
  assign hb_gap  = {{(TIME_W-GAP_W){1'b0}}, cfg.heartbeat_gap_ms};

  always_comb begin
    ever_nxt      = ever_r;
    held_cnt_nxt  = held_cnt_r;
    held_time_nxt = held_time_r;
    held_rssi_nxt = held_rssi_r;
    seq_nxt       = seq_r;
    last_send_nxt = last_send_r;
    pending_nxt   = pending_r;
    due_nxt       = due_r;

    rep_due = item.now_ms + {{(TIME_W-JIT_W){1'b0}}, item.report_jitter_ms};
    floor_t = last_send_r + min_gap;

    if (step_en && item.pkt_heard) begin
      ever_nxt      = 1'b1;
      held_cnt_nxt  = item.pkt_count;
      held_time_nxt = item.now_ms;
      held_rssi_nxt = (!item.pkt_rssi[7] && (item.pkt_rssi != 8'sd0)) ? 8'sd0 : item.pkt_rssi;
      if (!pending_r) begin
        pending_nxt = 1'b1;
        due_nxt     = (rep_due < floor_t) ? floor_t : rep_due;
      end
    end

    since_pkt  = item.now_ms - held_time_nxt;
    since_send = item.now_ms - last_send_r;
    silent     = !ever_nxt || (since_pkt >= hb_gap);

    if (step_en && silent && !pending_nxt && (since_send >= hb_gap)) begin
      pending_nxt = 1'b1;
      due_nxt     = item.now_ms + {{(TIME_W-JIT_W){1'b0}}, item.heartbeat_jitter_ms};
    end

    fire   = step_en && pending_nxt && !(item.now_ms < due_nxt);
    recent = ever_nxt && (since_pkt < hb_gap);

    if (fire) begin
      pending_nxt   = 1'b0;
      last_send_nxt = item.now_ms;
      seq_nxt       = seq_r + 32'd1;
    end

    res.report_time = item.now_ms;
    res.report_seq  = seq_r;
    res.sat_seq     = recent ? held_cnt_nxt : '0;
    res.sat_time    = recent ? held_time_nxt : '0;
    res.sat_rssi    = recent ? held_rssi_nxt : RSSI_NONE;
    res.fix_flag    = item.fix_valid;
    res.latitude    = item.fix_valid ? item.latitude_bits : '0;
    res.longitude   = item.fix_valid ? item.longitude_bits : '0;
    res.altitude    = item.fix_valid ? item.altitude_bits : '0;
    res.sats        = item.sats_in_view;
  end

  assign stat.fire = fire;
  assign stat.seq  = seq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ever_r      <= 1'b0;
      held_cnt_r  <= '0;
      held_time_r <= '0;
      held_rssi_r <= RSSI_NONE;
      seq_r       <= '0;
      last_send_r <= '0;
      pending_r   <= 1'b0;
      due_r       <= '0;
    end else begin
      ever_r      <= ever_nxt;
      held_cnt_r  <= held_cnt_nxt;
      held_time_r <= held_time_nxt;
      held_rssi_r <= held_rssi_nxt;
      seq_r       <= seq_nxt;
      last_send_r <= last_send_nxt;
      pending_r   <= pending_nxt;
      due_r       <= due_nxt;
    end
  end

endmodule
